FILE: rtl/core/sta_pkg.sv
// Shared types, widths and codes for the similarity transform unit.
package sta_pkg;

  localparam int M_W   = 34;  // rotation matrix entry, Q2.30 with headroom
  localparam int R_W   = 37;  // rotated coordinate, Q16.16 unclamped
  localparam int NUM_W = 56;  // normal-mode dividend magnitude
  localparam int DEN_W = 32;  // normal-mode divisor, twice the scale
  localparam int QUO_W = 33;  // quotient bits resolved by the divider

  localparam logic [1:0] CMD_POINT   = 2'd0;
  localparam logic [1:0] CMD_TANGENT = 2'd1;
  localparam logic [1:0] CMD_NORMAL  = 2'd2;
  localparam logic [1:0] CMD_HOMOG   = 2'd3;

  localparam logic [2:0] REG_TRANS_X = 3'd0;
  localparam logic [2:0] REG_TRANS_Y = 3'd1;
  localparam logic [2:0] REG_TRANS_Z = 3'd2;
  localparam logic [2:0] REG_ROT_W   = 3'd3;
  localparam logic [2:0] REG_ROT_X   = 3'd4;
  localparam logic [2:0] REG_ROT_Y   = 3'd5;
  localparam logic [2:0] REG_ROT_Z   = 3'd6;
  localparam logic [2:0] REG_SCALE   = 3'd7;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic signed [31:0] in_w;
  } sta_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [31:0] out_w;
    logic               saturated;
  } sta_out_t;

  // Transform as seen by the datapath: matrix rows in order, then translation and scale.
  typedef struct packed {
    logic [8:0][M_W-1:0] m;
    logic [2:0][31:0]    trans;
    logic [30:0]         scale;
  } xform_t;

  // Item state that rides along the divider.
  typedef struct packed {
    logic [1:0]       cmd;
    logic [31:0]      w_out;
    logic [2:0][31:0] res;
    logic             sat;
    logic [2:0]       neg;
    logic [2:0]       rzero;
  } div_sb_t;

endpackage

FILE: rtl/core/sta_cfg.sv
// Configuration registers and the quaternion-to-matrix conversion.
module sta_cfg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  output sta_pkg::xform_t      xf
);
  import sta_pkg::*;

  localparam logic signed [31:0]    Q_ONE   = 32'sh4000_0000;
  localparam logic signed [M_W-1:0] M_ONE   = M_W'(64'sh4000_0000);
  localparam logic signed [63:0]    RND_29  = 64'sd268435456;

  logic [31:0] trans [3];
  logic [31:0] rot   [4];
  logic [30:0] scale;

  logic signed [31:0] qc [4];
  logic signed [63:0] pxx, pyy, pzz, pxy, pxz, pyz, pwx, pwy, pwz;
  logic signed [M_W-1:0] m [9];

  function automatic logic signed [31:0] qclamp(input logic [31:0] v);
    logic signed [31:0] s;
    s = $signed(v);
    if (s > Q_ONE) return Q_ONE;
    if (s < -Q_ONE) return -Q_ONE;
    return s;
  endfunction

  function automatic logic signed [M_W-1:0] rnd29(input logic signed [63:0] a);
    logic signed [63:0] t;
    t = (a + RND_29) >>> 29;
    return t[M_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      trans[0] <= '0;
      trans[1] <= '0;
      trans[2] <= '0;
      rot[0]   <= Q_ONE;
      rot[1]   <= '0;
      rot[2]   <= '0;
      rot[3]   <= '0;
      scale    <= 31'd65536;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_TRANS_X: trans[0] <= cfg_data;
        REG_TRANS_Y: trans[1] <= cfg_data;
        REG_TRANS_Z: trans[2] <= cfg_data;
        REG_ROT_W:   rot[0]   <= cfg_data;
        REG_ROT_X:   rot[1]   <= cfg_data;
        REG_ROT_Y:   rot[2]   <= cfg_data;
        REG_ROT_Z:   rot[3]   <= cfg_data;
        REG_SCALE:   scale    <= cfg_data[30:0];
        default:     scale    <= scale;
      endcase
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) qc[k] = qclamp(rot[k]);
  end

  // qc order: w, x, y, z
  always_ff @(posedge clk) begin
    pxx <= qc[1] * qc[1];
    pyy <= qc[2] * qc[2];
    pzz <= qc[3] * qc[3];
    pxy <= qc[1] * qc[2];
    pxz <= qc[1] * qc[3];
    pyz <= qc[2] * qc[3];
    pwx <= qc[0] * qc[1];
    pwy <= qc[0] * qc[2];
    pwz <= qc[0] * qc[3];
  end

  always_ff @(posedge clk) begin
    m[0] <= M_ONE - rnd29(pyy + pzz);
    m[1] <= rnd29(pxy - pwz);
    m[2] <= rnd29(pxz + pwy);
    m[3] <= rnd29(pxy + pwz);
    m[4] <= M_ONE - rnd29(pxx + pzz);
    m[5] <= rnd29(pyz - pwx);
    m[6] <= rnd29(pxz - pwy);
    m[7] <= rnd29(pyz + pwx);
    m[8] <= M_ONE - rnd29(pxx + pyy);
  end

  always_comb begin
    for (int k = 0; k < 9; k++) xf.m[k] = m[k];
    for (int k = 0; k < 3; k++) xf.trans[k] = trans[k];
    xf.scale = scale;
  end

endmodule

FILE: rtl/core/sta_div.sv
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit a stage.
module sta_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  in_valid,
  input  logic [2:0][sta_pkg::NUM_W-1:0]        num,
  input  logic [sta_pkg::DEN_W-1:0]             den,
  input  sta_pkg::div_sb_t                      in_sb,
  output logic                                  out_valid,
  output logic [2:0][sta_pkg::QUO_W-1:0]        quot,
  output logic [2:0]                            ovf,
  output sta_pkg::div_sb_t                      out_sb
);
  import sta_pkg::*;

  localparam int CW = DEN_W + QUO_W;

  logic [QUO_W:0]     vld;
  logic [NUM_W-1:0]   rem [QUO_W][3];
  logic [QUO_W-1:0]   q   [QUO_W+1][3];
  logic [2:0]         ov  [QUO_W+1];
  div_sb_t            sb  [QUO_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[QUO_W-1:0], in_valid};
    end
  end

  // first stage: flag quotients that cannot fit in QUO_W bits
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        rem[0][l] <= num[l];
        q[0][l]   <= '0;
        ov[0][l]  <= CW'(num[l]) >= {den, {QUO_W{1'b0}}};
      end
      sb[0] <= in_sb;
    end
  end

  for (genvar s = 1; s <= QUO_W; s++) begin : g_stage
    localparam int B = QUO_W - s;
    always_ff @(posedge clk) begin
      if (en) begin
        ov[s] <= ov[s-1];
        sb[s] <= sb[s-1];
      end
    end
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [CW-1:0] shd;
      logic [CW-1:0] diff;
      logic          ge;
      assign shd  = CW'(den) << B;
      assign ge   = CW'(rem[s-1][l]) >= shd;
      assign diff = CW'(rem[s-1][l]) - shd;
      always_ff @(posedge clk) begin
        if (en) begin
          q[s][l] <= q[s-1][l] | (QUO_W'(ge) << B);
        end
      end
      if (s < QUO_W) begin : g_rem
        always_ff @(posedge clk) begin
          if (en) begin
            rem[s][l] <= ge ? diff[NUM_W-1:0] : rem[s-1][l];
          end
        end
      end
    end
  end

  assign out_valid = vld[QUO_W];
  assign ovf       = ov[QUO_W];
  assign out_sb    = sb[QUO_W];
  always_comb begin
    for (int l = 0; l < 3; l++) quot[l] = q[QUO_W][l];
  end

endmodule

FILE: rtl/core/similarity_transform_apply_unit.sv
// Top level of the similarity transform unit: datapath pipeline and output register.
//
// Applies rotation (quaternion), uniform scale and translation to one vector per
// beat in point, tangent, normal or homogeneous mode, with signed saturation. One
// beat is taken every cycle while the output side keeps up. Every item passes
// through the 34-stage divider pipeline that serves normal mode, so that results
// stay in order. A stall on the output freezes the whole pipeline. After reset or
// a register write the derived rotation matrix is rebuilt through the product
// and matrix registers of sta_cfg; an item reads it only as it moves from s1 to
// s2, so items may follow from the cycle after the write.
module similarity_transform_apply_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  sta_pkg::sta_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output sta_pkg::sta_out_t out_data,
  input  logic              cfg_wen,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import sta_pkg::*;

  localparam logic signed [52:0] SAT_MAX = 53'sd2147483647;
  localparam logic signed [52:0] SAT_MIN = -53'sd2147483648;

  xform_t xf;
  logic   adv;
  logic [7:0] vld;

  logic [1:0]         s0_cmd, s1_cmd, s2_cmd, s3_cmd, s4_cmd, s5_cmd, s6_cmd;
  logic signed [31:0] s0_w, s1_w, s2_w, s3_w, s4_w, s5_w, s6_w;
  logic signed [31:0] s0_v [3];
  logic signed [31:0] s1_v [3];
  logic signed [63:0] s1_wt [3];
  logic signed [63:0] s2_wt [3];
  logic signed [49:0] s2_ph [3][3];
  logic signed [50:0] s2_pl [3][3];
  logic signed [51:0] s3_hi [3];
  logic signed [52:0] s3_lo [3];
  logic signed [47:0] s3_wtr [3];
  logic signed [47:0] s4_wtr [3];
  logic signed [47:0] s5_wtr [3];
  logic signed [47:0] s6_wtr [3];
  logic signed [R_W-1:0] s4_r [3];
  logic signed [52:0] s5_sph [3];
  logic signed [53:0] s5_spl [3];
  logic signed [51:0] s6_acc [3];
  logic [2:0][NUM_W-1:0] s5_num, s6_num, s7_num;
  logic [2:0]         s5_neg, s6_neg, s5_rz, s6_rz;
  div_sb_t            s7_sb;

  logic [DEN_W-1:0]   den;
  logic signed [R_W-1:0] r_nxt [3];
  logic [2:0][NUM_W-1:0] num_nxt;
  logic [2:0]         neg_nxt;
  logic signed [51:0] acc_nxt [3];
  div_sb_t            sb_nxt;

  logic                    d_valid;
  logic [2:0][QUO_W-1:0]   d_quot;
  logic [2:0]              d_ovf;
  div_sb_t                 d_sb;
  sta_out_t                out_nxt;

  sta_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .xf        (xf)
  );

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign den      = {xf.scale, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[6:0], in_valid};
    end
  end

  // rotated coordinate and normal-mode dividend
  always_comb begin
    logic signed [69:0]    tot;
    logic signed [NUM_W-1:0] n;
    for (int i = 0; i < 3; i++) begin
      tot      = (70'(s3_hi[i]) <<< 16) + 70'(s3_lo[i]) + 70'sd536870912;
      r_nxt[i] = tot[R_W+29:30];
    end
    for (int i = 0; i < 3; i++) begin
      n          = (NUM_W'(s4_r[i]) <<< 17) + $signed(NUM_W'(xf.scale));
      neg_nxt[i] = n[NUM_W-1];
      num_nxt[i] = neg_nxt[i] ? NUM_W'(-n + $signed(NUM_W'(den)) - NUM_W'(1)) : n;
    end
  end

  always_comb begin
    logic signed [69:0] t;
    for (int i = 0; i < 3; i++) begin
      t          = (70'(s5_sph[i]) <<< 16) + 70'(s5_spl[i]) + 70'sd32768;
      acc_nxt[i] = t[67:16];
    end
  end

  // translation add and clamp for the non-normal modes
  always_comb begin
    logic signed [52:0] add;
    logic signed [52:0] sum;
    sb_nxt       = '0;
    sb_nxt.cmd   = s6_cmd;
    sb_nxt.w_out = (s6_cmd == CMD_HOMOG) ? s6_w : '0;
    sb_nxt.neg   = s6_neg;
    sb_nxt.rzero = s6_rz;
    for (int i = 0; i < 3; i++) begin
      priority if (s6_cmd == CMD_POINT) add = 53'($signed(xf.trans[i]));
      else if (s6_cmd == CMD_HOMOG)     add = 53'(s6_wtr[i]);
      else                              add = '0;
      sum = 53'(s6_acc[i]) + add;
      priority if (sum > SAT_MAX) begin
        sb_nxt.res[i] = 32'h7FFF_FFFF;
        sb_nxt.sat    = 1'b1;
      end else if (sum < SAT_MIN) begin
        sb_nxt.res[i] = 32'h8000_0000;
        sb_nxt.sat    = 1'b1;
      end else begin
        sb_nxt.res[i] = sum[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_cmd  <= in_data.cmd;
      s0_w    <= in_data.in_w;
      s0_v[0] <= in_data.in_x;
      s0_v[1] <= in_data.in_y;
      s0_v[2] <= in_data.in_z;

      s1_cmd <= s0_cmd;
      s1_w   <= s0_w;
      for (int i = 0; i < 3; i++) begin
        s1_v[i]  <= s0_v[i];
        s1_wt[i] <= s0_w * $signed(xf.trans[i]);
      end

      s2_cmd <= s1_cmd;
      s2_w   <= s1_w;
      for (int i = 0; i < 3; i++) begin
        s2_wt[i] <= s1_wt[i];
        for (int j = 0; j < 3; j++) begin
          s2_ph[i][j] <= $signed(xf.m[3*i+j]) * $signed(s1_v[j][31:16]);
          s2_pl[i][j] <= $signed(xf.m[3*i+j]) * $signed({1'b0, s1_v[j][15:0]});
        end
      end

      s3_cmd <= s2_cmd;
      s3_w   <= s2_w;
      for (int i = 0; i < 3; i++) begin
        s3_hi[i]  <= s2_ph[i][0] + s2_ph[i][1] + s2_ph[i][2];
        s3_lo[i]  <= s2_pl[i][0] + s2_pl[i][1] + s2_pl[i][2];
        s3_wtr[i] <= 48'((s2_wt[i] + 64'sd32768) >>> 16);
      end

      s4_cmd <= s3_cmd;
      s4_w   <= s3_w;
      for (int i = 0; i < 3; i++) begin
        s4_r[i]   <= r_nxt[i];
        s4_wtr[i] <= s3_wtr[i];
      end

      s5_cmd <= s4_cmd;
      s5_w   <= s4_w;
      s5_num <= num_nxt;
      s5_neg <= neg_nxt;
      for (int i = 0; i < 3; i++) begin
        s5_sph[i] <= s4_r[i] * $signed({1'b0, xf.scale[30:16]});
        s5_spl[i] <= s4_r[i] * $signed({1'b0, xf.scale[15:0]});
        s5_rz[i]  <= (s4_r[i] == '0);
        s5_wtr[i] <= s4_wtr[i];
      end

      s6_cmd <= s5_cmd;
      s6_w   <= s5_w;
      s6_num <= s5_num;
      s6_neg <= s5_neg;
      s6_rz  <= s5_rz;
      for (int i = 0; i < 3; i++) begin
        s6_acc[i] <= acc_nxt[i];
        s6_wtr[i] <= s5_wtr[i];
      end

      s7_num <= s6_num;
      s7_sb  <= sb_nxt;
    end
  end

  sta_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (vld[7]),
    .num       (s7_num),
    .den       (den),
    .in_sb     (s7_sb),
    .out_valid (d_valid),
    .quot      (d_quot),
    .ovf       (d_ovf),
    .out_sb    (d_sb)
  );

  // normal-mode clamp and mode select
  always_comb begin
    logic [31:0] res [3];
    logic [2:0]  fl;
    logic        szero;
    szero = (xf.scale == '0);
    fl    = '0;
    for (int i = 0; i < 3; i++) begin
      res[i] = d_sb.res[i];
      if (szero) begin
        priority if (d_sb.rzero[i]) res[i] = '0;
        else if (d_sb.neg[i])       res[i] = 32'h8000_0000;
        else                        res[i] = 32'h7FFF_FFFF;
        fl[i] = !d_sb.rzero[i];
      end else if (d_sb.neg[i]) begin
        fl[i]  = d_ovf[i] || (d_quot[i] > QUO_W'(33'h0_8000_0000));
        res[i] = fl[i] ? 32'h8000_0000 : 32'(-d_quot[i]);
      end else begin
        fl[i]  = d_ovf[i] || (d_quot[i][QUO_W-1:31] != '0);
        res[i] = fl[i] ? 32'h7FFF_FFFF : d_quot[i][31:0];
      end
    end
    if (d_sb.cmd == CMD_NORMAL) begin
      out_nxt.out_x     = res[0];
      out_nxt.out_y     = res[1];
      out_nxt.out_z     = res[2];
      out_nxt.saturated = |fl;
    end else begin
      out_nxt.out_x     = d_sb.res[0];
      out_nxt.out_y     = d_sb.res[1];
      out_nxt.out_z     = d_sb.res[2];
      out_nxt.saturated = d_sb.sat;
    end
    out_nxt.out_w = d_sb.w_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= out_nxt;
    end
  end

endmodule
